### rtl/morse_keying_encoder_assert.svh
// Assertion macros for the Morse keying encoder.
`ifndef MORSE_KEYING_ENCODER_ASSERT_SVH
`define MORSE_KEYING_ENCODER_ASSERT_SVH

`ifndef SYNTH
`define MKE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MKE_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define MKE_ASSERT(lbl, clk, rst_n, prop, msg)
`define MKE_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif

`endif

### rtl/mke_pkg.sv
// Shared types, character codes and the Morse symbol table.
package mke_pkg;

  typedef enum logic [1:0] {
    SYM_NONE,
    SYM_SPACE,
    SYM_CODE
  } sym_kind_t;

  // pat: first element in the top bit, 1 is a dash, 0 a dot
  typedef struct packed {
    sym_kind_t   kind;
    logic [2:0]  len;
    logic [4:0]  pat;
  } sym_t;

  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_UP_A   = 8'h41;
  localparam logic [7:0] CHAR_UP_Z   = 8'h5A;
  localparam logic [7:0] CHAR_LO_A   = 8'h61;
  localparam logic [7:0] CHAR_LO_Z   = 8'h7A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  localparam int unsigned TABLE_DEPTH = 36;
  localparam logic [5:0]  DIGIT_BASE  = 6'd26;

  // {len, pat}; entries 0..25 are A..Z, 26..35 are 0..9
  localparam logic [7:0] CODE_TABLE [TABLE_DEPTH] = '{
    {3'd2, 5'b01000}, {3'd4, 5'b10000}, {3'd4, 5'b10100}, {3'd3, 5'b10000},
    {3'd1, 5'b00000}, {3'd4, 5'b00100}, {3'd3, 5'b11000}, {3'd4, 5'b00000},
    {3'd2, 5'b00000}, {3'd4, 5'b01110}, {3'd3, 5'b10100}, {3'd4, 5'b01000},
    {3'd2, 5'b11000}, {3'd2, 5'b10000}, {3'd3, 5'b11100}, {3'd4, 5'b01100},
    {3'd4, 5'b11010}, {3'd3, 5'b01000}, {3'd3, 5'b00000}, {3'd1, 5'b10000},
    {3'd3, 5'b00100}, {3'd4, 5'b00010}, {3'd3, 5'b01100}, {3'd4, 5'b10010},
    {3'd4, 5'b10110}, {3'd4, 5'b11000},
    {3'd5, 5'b11111}, {3'd5, 5'b01111}, {3'd5, 5'b00111}, {3'd5, 5'b00011},
    {3'd5, 5'b00001}, {3'd5, 5'b00000}, {3'd5, 5'b10000}, {3'd5, 5'b11000},
    {3'd5, 5'b11100}, {3'd5, 5'b11110}
  };

endpackage

### rtl/mke_lookup.sv
// Case fold and Morse table lookup for one character.
module mke_lookup (
  input  logic [7:0]    character,
  output mke_pkg::sym_t sym
);

  logic [7:0] ch;
  logic [5:0] idx;
  logic [7:0] entry;
  logic       is_letter;
  logic       is_digit;

  always_comb begin
    ch = character;
    if (character >= mke_pkg::CHAR_LO_A && character <= mke_pkg::CHAR_LO_Z) begin
      ch = character - mke_pkg::CASE_OFFSET;
    end
    is_letter = (ch >= mke_pkg::CHAR_UP_A) && (ch <= mke_pkg::CHAR_UP_Z);
    is_digit  = (ch >= mke_pkg::CHAR_ZERO) && (ch <= mke_pkg::CHAR_NINE);
    idx = 6'd0;
    if (is_letter) begin
      idx = 6'(ch - mke_pkg::CHAR_UP_A);
    end else if (is_digit) begin
      idx = 6'(ch - mke_pkg::CHAR_ZERO) + mke_pkg::DIGIT_BASE;
    end
    entry = mke_pkg::CODE_TABLE[idx];
    sym.len = entry[7:5];
    sym.pat = entry[4:0];
    if (ch == mke_pkg::CHAR_SPACE) begin
      sym.kind = mke_pkg::SYM_SPACE;
    end else if (is_letter || is_digit) begin
      sym.kind = mke_pkg::SYM_CODE;
    end else begin
      sym.kind = mke_pkg::SYM_NONE;
    end
  end

endmodule

### rtl/morse_keying_encoder.sv
// Morse keying encoder: one ASCII character in, one keying unit per output word.
//
// Input channel in_*: one word per character, in_tdata is the ASCII code.
// Lower case is folded to upper case; A-Z and 0-9 are keyed from the
// International Morse table, a space gives four units off, anything else
// gives only the two-unit character gap.
// Output channel out_*: one word per time unit, out_tdata[0] is the key
// level (1 tone on) and out_tlast marks the final unit of the character.
// On taking a character the sequencer leaves idle, then registers the first unit.
// Throughput: a new character is taken only once the last unit of the
// previous one is emitted (a five-dash digit has the longest run). The unit
// sequencer emits one unit per cycle while the receiver takes them, through
// unit and element down counters; in_tready is high only while it is idle.
// When the receiver stalls, the output word holds and the sequencer waits.
// Reset empties the output register and returns the sequencer to idle.
`include "morse_keying_encoder_assert.svh"

module morse_keying_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] character
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [0] key_on, [7:1] zero
  output logic       out_tlast   // last_unit
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ON,
    S_OFF,
    S_GAP
  } state_t;

  state_t        state_r;
  logic [1:0]    cnt_r;
  logic [2:0]    left_r;
  logic [4:0]    pat_r;
  logic          out_tvalid_r;
  logic          key_on_r;
  logic          last_unit_r;
  mke_pkg::sym_t sym;
  logic          in_acc;
  logic          emit;

  mke_lookup u_lookup (
    .character (in_tdata),
    .sym       (sym)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign emit      = (state_r != S_IDLE) && (!out_tvalid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            unique case (sym.kind)
              mke_pkg::SYM_SPACE: begin
                state_r <= S_GAP;
                cnt_r   <= 2'd3;
                left_r  <= 3'd0;
              end
              mke_pkg::SYM_CODE: begin
                state_r <= S_ON;
                cnt_r   <= sym.pat[4] ? 2'd2 : 2'd0;
                pat_r   <= {sym.pat[3:0], 1'b0};
                left_r  <= sym.len - 3'd1;
              end
              default: begin
                state_r <= S_GAP;
                cnt_r   <= 2'd1;
                left_r  <= 3'd0;
              end
            endcase
          end
        end
        S_ON: begin
          if (emit) begin
            key_on_r     <= 1'b1;
            last_unit_r  <= 1'b0;
            if (cnt_r == 2'd0) begin
              state_r <= S_OFF;
            end else begin
              cnt_r <= cnt_r - 2'd1;
            end
          end
        end
        S_OFF: begin
          if (emit) begin
            key_on_r     <= 1'b0;
            last_unit_r  <= 1'b0;
            if (left_r == 3'd0) begin
              state_r <= S_GAP;
              cnt_r   <= 2'd1;
            end else begin
              state_r <= S_ON;
              cnt_r   <= pat_r[4] ? 2'd2 : 2'd0;
              pat_r   <= {pat_r[3:0], 1'b0};
              left_r  <= left_r - 3'd1;
            end
          end
        end
        S_GAP: begin
          if (emit) begin
            key_on_r     <= 1'b0;
            last_unit_r  <= (cnt_r == 2'd0);
            if (cnt_r == 2'd0) begin
              state_r <= S_IDLE;
            end else begin
              cnt_r <= cnt_r - 2'd1;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'd0, key_on_r};
  assign out_tlast  = last_unit_r;

  `MKE_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_acc, !in_tready, "ready after accept")
  `MKE_ASSERT(a_last_is_off, clk, rst_n, (out_tvalid && out_tlast) |-> !out_tdata[0], "tone on last unit")
  `MKE_ASSERT(a_gap_no_elems, clk, rst_n, (state_r == S_GAP) |-> (left_r == 3'd0), "elements left in gap")
  `MKE_ASSERT_NEXT(a_hold_stall, clk, rst_n, (out_tvalid && !out_tready), (out_tvalid && $stable(out_tlast) && $stable(out_tdata)), "word changed under stall")

endmodule
